/* hdl/rlpg_pkg.sv */
// ============================================================================
// rlpg_pkg : shared types and constants of the road layer pixel generator
// Request codes, register indexes, priority tables and memory geometry.
// ============================================================================
`default_nettype none

package rlpg_pkg;

  localparam int ROM_BYTES    = 65536;
  localparam int RAM_WORDS    = 2048;
  localparam int SCREEN_LINES = 224;
  localparam int LINE_PIXELS  = 320;
  localparam int LINE_LIMIT   = (LINE_PIXELS / 2) * 2;

  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_AW      = 3;

  localparam logic [11:0] SCROLL_BASE  = 12'h5f8;
  localparam logic [15:0] SWAP_RESULT  = 16'hffff;

  typedef enum logic [1:0] {
    REQ_RAM_WR = 2'd0,
    REQ_SWAP   = 2'd1,
    REQ_ROM_LD = 2'd2,
    REQ_RENDER = 2'd3
  } req_e_t;

  typedef enum logic [2:0] {
    CFG_ROAD_MODE    = 3'd0,
    CFG_STRIPE_BASE  = 3'd1,
    CFG_GROUND_BASE  = 3'd2,
    CFG_SOLID_BASE   = 3'd3,
    CFG_SCROLL_ADJ   = 3'd4,
    CFG_SCREEN_SHIFT = 3'd5
  } cfg_idx_t;

  localparam logic [1:0] MODE_ROAD0_ONLY  = 2'd0;
  localparam logic [1:0] MODE_ROAD0_FIRST = 2'd1;
  localparam logic [1:0] MODE_ROAD1_FIRST = 2'd2;
  localparam logic [1:0] MODE_ROAD1_ONLY  = 2'd3;

  typedef logic [7:0] prio_row_t;
  localparam prio_row_t PRIO_ROAD0_FIRST [8] = '{8'h80, 8'h81, 8'h81, 8'h87,
                                                 8'h00, 8'h00, 8'h00, 8'h00};
  localparam prio_row_t PRIO_ROAD1_FIRST [8] = '{8'h81, 8'h81, 8'h81, 8'h8f,
                                                 8'h00, 8'h00, 8'h00, 8'h80};

  typedef struct packed {
    logic [1:0]  ctrl;
    logic        direct;
    logic [10:0] stripe_base;
    logic [10:0] ground_base;
    logic [10:0] solid_base;
    logic [11:0] scroll_adjust;
    logic [11:0] screen_shift;
  } rlpg_cfg_t;

  typedef struct packed {
    logic        pixel_write;
    logic [10:0] pixel_color;
  } rlpg_pix_t;

endpackage

`default_nettype wire

/* hdl/rlpg_mix.sv */
// ============================================================================
// rlpg_mix : pixel decode and layer mix
// Turns the fetched line entries and bitmap bytes of both roads into one
// palette index, with priority mixing and the solid background fallback.
// ============================================================================
`default_nettype none

module rlpg_mix (
  input  rlpg_pkg::rlpg_cfg_t  cfg,
  input  logic                 render,
  input  logic                 on_screen,
  input  logic [15:0]          d0,
  input  logic [15:0]          d1,
  input  logic [15:0]          c0,
  input  logic [15:0]          c1,
  input  logic [11:0]          h0,
  input  logic [11:0]          h1,
  input  logic [7:0]           rom0a,
  input  logic [7:0]           rom0b,
  input  logic [7:0]           rom1a,
  input  logic [7:0]           rom1b,
  output rlpg_pkg::rlpg_pix_t  pix
);
  import rlpg_pkg::*;

  function automatic logic [2:0] fetch_px(input logic solid, input logic [11:0] h,
                                          input logic [7:0] pa, input logic [7:0] pb);
    logic [2:0] sh;
    logic [1:0] v;
    logic [2:0] p;
    sh = ~h[2:0];
    v  = {pb[sh], pa[sh]};
    p  = {1'b0, v};
    if (h[11:3] == 9'h01f && v == 2'd3) begin
      p = 3'd7;
    end
    if (solid || h[11:9] != 3'd0) begin
      p = 3'd3;
    end
    return p;
  endfunction

  function automatic logic [10:0] color_of(input logic r, input logic [2:0] p,
                                           input logic [15:0] d, input logic [15:0] c,
                                           input logic [10:0] stripe,
                                           input logic [10:0] ground);
    logic [10:0] x;
    logic [1:0]  k;
    logic [10:0] res;
    x = r ? 11'h008 : 11'h000;
    k = (p == 3'd7) ? 2'd3 : p[1:0];
    if (p == 3'd3) begin
      if (d[9]) begin
        res = stripe ^ x ^ {10'd0, c[{1'b0, r, 2'b00}]};
      end else begin
        res = ground ^ (r ? 11'h010 : 11'h000) ^ {7'd0, c[11:8]};
      end
    end else begin
      res = stripe ^ x ^ {8'd0, k, 1'b0} ^ {10'd0, c[{1'b0, r, k}]};
    end
    return res;
  endfunction

  logic        s0, s1;
  logic [2:0]  p0, p1;
  logic        use1, fg, bg_vld;
  logic [6:0]  bg;
  logic [10:0] fg_color;
  prio_row_t   row0, row1;

  assign s0   = d0[11];
  assign s1   = d1[11];
  assign p0   = fetch_px(s0, h0, rom0a, rom0b);
  assign p1   = fetch_px(s1, h1, rom1a, rom1b);
  assign row0 = PRIO_ROAD0_FIRST[p0];
  assign row1 = PRIO_ROAD1_FIRST[p0];

  always_comb begin
    case (cfg.ctrl)
      MODE_ROAD0_ONLY:  use1 = 1'b0;
      MODE_ROAD0_FIRST: use1 = row0[p1];
      MODE_ROAD1_FIRST: use1 = row1[p1];
      MODE_ROAD1_ONLY:  use1 = 1'b1;
      default:          use1 = 1'b0;
    endcase
  end

  always_comb begin
    bg_vld = 1'b0;
    bg     = 7'd0;
    if (cfg.ctrl == MODE_ROAD0_ONLY || cfg.ctrl == MODE_ROAD0_FIRST) begin
      if (s0) begin
        bg_vld = 1'b1;
        bg     = d0[6:0];
      end else if (cfg.ctrl == MODE_ROAD0_FIRST && s1) begin
        bg_vld = 1'b1;
        bg     = d1[6:0];
      end
    end else begin
      if (s1) begin
        bg_vld = 1'b1;
        bg     = d1[6:0];
      end else if (cfg.ctrl == MODE_ROAD1_FIRST && s0) begin
        bg_vld = 1'b1;
        bg     = d0[6:0];
      end
    end
  end

  assign fg = !(s0 && s1) && !(cfg.ctrl == MODE_ROAD0_ONLY && s0)
           && !(cfg.ctrl == MODE_ROAD1_ONLY && s1);
  assign fg_color = use1 ? color_of(1'b1, p1, d1, c1, cfg.stripe_base, cfg.ground_base)
                         : color_of(1'b0, p0, d0, c0, cfg.stripe_base, cfg.ground_base);

  always_comb begin
    pix = '0;
    if (render && on_screen) begin
      if (fg) begin
        pix.pixel_write = 1'b1;
        pix.pixel_color = fg_color;
      end else if (bg_vld) begin
        pix.pixel_write = 1'b1;
        pix.pixel_color = {4'd0, bg} | cfg.solid_base;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/road_layer_pixel_generator_core.sv */
// ============================================================================
// road_layer_pixel_generator_core : two-layer road pixel generator
// Road RAM and bitmap ROM stores with a four-stage read and mix pipeline.
// ============================================================================
// Usage:
//   in_*  : one request per transfer. tuser carries the request kind (RAM
//           write, bank swap, ROM byte load, pixel render), tdata the address,
//           write value, scanline and column.
//   out_* : exactly one result per request, in request order: pixel write
//           flag, palette index and the swap read value.
//   cfg_* : register writes; user writes only with no request in flight, unchecked.
// Throughput is one request per cycle while in_tready is high. Line entries,
// then scroll and colour words, then bitmap bytes are read in turn, each one
// synchronous memory read; the road RAM is split by region, with the bank in
// the top address bit, the ROM by road and bit plane, so every read but the
// two colour-word reads of ram_d has its own port. Results queue in an
// eight-entry output buffer; in_tready drops only once eight requests are
// accepted but not yet taken, so a stalled receiver holds the pipeline back
// after that many transfers. Reset clears the bank select and the buffer and
// presets the registers; RAM and ROM contents are undefined until written.
// ============================================================================
`default_nettype none

module road_layer_pixel_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // address[15:0], write_value[31:16], scanline[39:32],
                                  // column[48:40], zero fill
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_write[0], pixel_color[11:1], read_value[27:12],
                                  // zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);
  import rlpg_pkg::*;

  // configuration registers
  rlpg_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctrl          <= 2'd0;
      cfg_r.direct        <= 1'b0;
      cfg_r.stripe_base   <= 11'd1024;
      cfg_r.ground_base   <= 11'd1056;
      cfg_r.solid_base    <= 11'd1920;
      cfg_r.scroll_adjust <= 12'd0;
      cfg_r.screen_shift  <= 12'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ROAD_MODE: begin
          cfg_r.ctrl   <= cfg_wdata[1:0];
          cfg_r.direct <= cfg_wdata[2];
        end
        CFG_STRIPE_BASE:  cfg_r.stripe_base   <= cfg_wdata[10:0];
        CFG_GROUND_BASE:  cfg_r.ground_base   <= cfg_wdata[10:0];
        CFG_SOLID_BASE:   cfg_r.solid_base    <= cfg_wdata[10:0];
        CFG_SCROLL_ADJ:   cfg_r.scroll_adjust <= cfg_wdata;
        CFG_SCREEN_SHIFT: cfg_r.screen_shift  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input unpack
  logic        acc;
  req_e_t      in_req;
  logic [15:0] in_addr, in_val;
  logic [7:0]  in_y;
  logic [8:0]  in_x;
  logic        in_on;

  assign acc     = in_tvalid && in_tready;
  assign in_req  = req_e_t'(in_tuser);
  assign in_addr = in_tdata[15:0];
  assign in_val  = in_tdata[31:16];
  assign in_y    = in_tdata[39:32];
  assign in_x    = in_tdata[48:40];
  assign in_on   = ({1'b0, in_y} < 9'(SCREEN_LINES)) && ({1'b0, in_x} < 10'(LINE_LIMIT));

  // display bank
  logic bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (acc && in_req == REQ_SWAP) begin
      bank_r <= ~bank_r;
    end
  end

  // road RAM, split by region, bank in the top address bit
  logic [15:0] ram_a0 [512];
  logic [15:0] ram_a1 [512];
  logic [15:0] ram_b  [1024];
  logic [15:0] ram_c  [1024];
  logic [15:0] ram_d  [1024];
  logic [10:0] wr_idx;
  logic        ram_we;

  assign wr_idx = in_addr[10:0];
  assign ram_we = acc && in_req == REQ_RAM_WR;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      case (wr_idx[10:9])
        2'd0: begin
          if (wr_idx[8]) begin
            ram_a1[{~bank_r, wr_idx[7:0]}] <= in_val;
          end else begin
            ram_a0[{~bank_r, wr_idx[7:0]}] <= in_val;
          end
        end
        2'd1:    ram_b[{~bank_r, wr_idx[8:0]}] <= in_val;
        2'd2:    ram_c[{~bank_r, wr_idx[8:0]}] <= in_val;
        default: ram_d[{~bank_r, wr_idx[8:0]}] <= in_val;
      endcase
    end
  end

  // stage 1: line entries
  logic        s1_vld_r, s1_on_r, s1_bank_r;
  req_e_t      s1_req_r;
  logic [15:0] s1_addr_r, s1_val_r;
  logic [7:0]  s1_y_r;
  logic [8:0]  s1_x_r;
  logic [15:0] d0_q_r, d1_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r  <= in_req;
    s1_addr_r <= in_addr;
    s1_val_r  <= in_val;
    s1_y_r    <= in_y;
    s1_x_r    <= in_x;
    s1_on_r   <= in_on;
    s1_bank_r <= bank_r;
    d0_q_r    <= ram_a0[{bank_r, in_y}];
    d1_q_r    <= ram_a1[{bank_r, in_y}];
  end

  // stage 2: scroll and colour words
  logic [8:0]  i0, i1;
  logic        s2_vld_r, s2_on_r;
  req_e_t      s2_req_r;
  logic [15:0] s2_addr_r, s2_val_r;
  logic [8:0]  s2_x_r;
  logic [15:0] s2_d0_r, s2_d1_r;
  logic [15:0] hp0_q_r, hp1_q_r, c0_q_r, c1_q_r;

  assign i0 = cfg_r.direct ? {1'b0, s1_y_r} : d0_q_r[8:0];
  assign i1 = cfg_r.direct ? {1'b1, s1_y_r} : d1_q_r[8:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_req_r  <= s1_req_r;
    s2_addr_r <= s1_addr_r;
    s2_val_r  <= s1_val_r;
    s2_x_r    <= s1_x_r;
    s2_on_r   <= s1_on_r;
    s2_d0_r   <= d0_q_r;
    s2_d1_r   <= d1_q_r;
    hp0_q_r   <= ram_b[{s1_bank_r, i0}];
    hp1_q_r   <= ram_c[{s1_bank_r, i1}];
    c0_q_r    <= ram_d[{s1_bank_r, i0}];
    c1_q_r    <= ram_d[{s1_bank_r, i1}];
  end

  // stage 3: bitmap bytes; ROM loads go in at this stage to keep request order
  logic [7:0]  rom_q0 [16384];
  logic [7:0]  rom_q1 [16384];
  logic [7:0]  rom_q2 [16384];
  logic [7:0]  rom_q3 [16384];
  logic [11:0] off, h0, h1;
  logic [13:0] ra0, ra1;
  logic        rom_we;

  assign off    = SCROLL_BASE + cfg_r.screen_shift + cfg_r.scroll_adjust;
  assign h0     = hp0_q_r[11:0] - off + {3'd0, s2_x_r};
  assign h1     = hp1_q_r[11:0] - off + {3'd0, s2_x_r};
  assign ra0    = {s2_d0_r[8:1], h0[8:3]};
  assign ra1    = {s2_d1_r[8:1], h1[8:3]};
  assign rom_we = s2_vld_r && s2_req_r == REQ_ROM_LD;

  always_ff @(posedge clk) begin
    if (rom_we) begin
      case (s2_addr_r[15:14])
        2'd0:    rom_q0[s2_addr_r[13:0]] <= s2_val_r[7:0];
        2'd1:    rom_q1[s2_addr_r[13:0]] <= s2_val_r[7:0];
        2'd2:    rom_q2[s2_addr_r[13:0]] <= s2_val_r[7:0];
        default: rom_q3[s2_addr_r[13:0]] <= s2_val_r[7:0];
      endcase
    end
  end

  logic        s3_vld_r, s3_on_r;
  req_e_t      s3_req_r;
  logic [15:0] s3_d0_r, s3_d1_r, s3_c0_r, s3_c1_r;
  logic [11:0] s3_h0_r, s3_h1_r;
  logic [7:0]  r0a_r, r0b_r, r1a_r, r1b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_req_r <= s2_req_r;
    s3_on_r  <= s2_on_r;
    s3_d0_r  <= s2_d0_r;
    s3_d1_r  <= s2_d1_r;
    s3_c0_r  <= c0_q_r;
    s3_c1_r  <= c1_q_r;
    s3_h0_r  <= h0;
    s3_h1_r  <= h1;
    r0a_r    <= rom_q0[ra0];
    r0b_r    <= rom_q1[ra0];
    r1a_r    <= rom_q2[ra1];
    r1b_r    <= rom_q3[ra1];
  end

  // stage 4: mix and queue
  rlpg_pix_t   pix;
  logic [27:0] res;

  rlpg_mix u_mix (
    .cfg       (cfg_r),
    .render    (s3_req_r == REQ_RENDER),
    .on_screen (s3_on_r),
    .d0        (s3_d0_r),
    .d1        (s3_d1_r),
    .c0        (s3_c0_r),
    .c1        (s3_c1_r),
    .h0        (s3_h0_r),
    .h1        (s3_h1_r),
    .rom0a     (r0a_r),
    .rom0b     (r0b_r),
    .rom1a     (r1a_r),
    .rom1b     (r1b_r),
    .pix       (pix)
  );

  assign res = {(s3_req_r == REQ_SWAP) ? SWAP_RESULT : 16'd0, pix.pixel_color,
                pix.pixel_write};

  logic [27:0]        fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   fifo_cnt_r, fifo_cnt_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign pop          = out_tvalid && out_tready;
  assign out_tvalid   = fifo_cnt_r != '0;
  assign out_tdata    = {4'd0, fifo_r[rd_ptr_r]};
  assign in_tready    = cnt_r < (FIFO_AW + 1)'(FIFO_DEPTH);
  assign cnt_nxt      = cnt_r + (FIFO_AW + 1)'(acc) - (FIFO_AW + 1)'(pop);
  assign fifo_cnt_nxt = fifo_cnt_r + (FIFO_AW + 1)'(s3_vld_r) - (FIFO_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      cnt_r      <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      cnt_r      <= cnt_nxt;
      if (s3_vld_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("request count beyond buffer depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (fifo_cnt_r < (FIFO_AW + 1)'(FIFO_DEPTH) || pop))
    else $error("result pushed into a full buffer");

  a_count_cover: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= cnt_r)
    else $error("buffer holds more results than requests in flight");

  a_swap_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_req == REQ_SWAP) |=> bank_r != $past(bank_r))
    else $error("bank swap did not toggle the display bank");

  a_blank_color: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && !pix.pixel_write) |-> pix.pixel_color == 11'd0)
    else $error("undrawn pixel carries a colour");

endmodule

`default_nettype wire

/* tb/tb_road_layer_pixel_generator_core.sv */
// ============================================================================
// tb_road_layer_pixel_generator_core : self-checking bench of the road layer
// pixel generator
// Renders a few screen lines whose line entries all point at ROM line zero.
// Fills every RAM word and ROM byte that those lines can reach, in both
// banks, then runs directed and random requests over several register
// settings. A behavioral model predicts each result, and every result is
// compared field by field. Both stream sides idle at random.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module tb_road_layer_pixel_generator_core;
  import rlpg_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [15:0] wval;
    logic [7:0]  line;
    logic [8:0]  col;
  } road_req_t;

  typedef struct packed {
    logic        pixel_write;
    logic [10:0] pixel_color;
    logic [15:0] read_value;
  } road_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [11:0] cfg_wdata;

  road_layer_pixel_generator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  road_req_t   pending_reqs[$];
  road_res_t   expected_pixels[$];
  road_req_t   held_req;
  int unsigned err_count = 0;
  int unsigned cyc = 0;

  logic [15:0] road_ram [2*RAM_WORDS];
  logic [7:0]  road_rom [ROM_BYTES];
  logic        shown_bank;
  logic [2:0]  m_mode;
  logic [10:0] m_stripe, m_ground, m_solid;
  logic [11:0] m_adj, m_shift;

  int unsigned lines_used [4] = '{0, 1, 100, 223};
  logic [15:0] ram_keys[$];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit calm();
    return (cyc % 5000) < 1200;
  endfunction

  // line entries keep ROM line zero and index 0 or 1
  function automatic logic [15:0] key_value(logic [15:0] a);
    logic [15:0] v;
    v = 16'($urandom);
    if (a[10:0] < 11'h200) v = v & 16'hfe01;
    return v;
  endfunction

  function automatic logic [15:0] rom_key();
    return 16'($urandom_range(0, 3) * 'h4000 + $urandom_range(0, 63));
  endfunction

  function automatic int unsigned shown_word(int unsigned idx);
    return road_ram[shown_bank*RAM_WORDS + (idx & (RAM_WORDS-1))];
  endfunction

  function automatic int unsigned road_value(int unsigned r, int unsigned d, int unsigned h);
    int unsigned base, sh, b0, b1, v;
    if (d[11] || h >= 'h200) return 3;
    base = (((d >> 1) & 'hff) * 'h40 + r * 'h8000) & 'hffff;
    sh = (~h) & 7;
    b0 = (road_rom[(base + (h >> 3)) & 'hffff] >> sh) & 1;
    b1 = (road_rom[(base + (h >> 3) + 'h4000) & 'hffff] >> sh) & 1;
    v = b0 | (b1 << 1);
    if (h >= 248 && h < 256 && v == 3) v = 7;
    return v;
  endfunction

  function automatic logic [10:0] road_shade(int unsigned r, int unsigned p,
                                             int unsigned d, int unsigned cb);
    int unsigned c, k;
    if (p == 3) begin
      if (d[9]) c = m_stripe ^ (r*8) ^ ((cb >> (r*4)) & 1);
      else c = m_ground ^ (r*'h10) ^ ((cb >> 8) & 'hf);
    end else begin
      k = (p == 7) ? 3 : (p & 3);
      c = m_stripe ^ (r*8) ^ (k*2) ^ ((cb >> (r*4 + k)) & 1);
    end
    return c[10:0];
  endfunction

  function automatic road_res_t road_pixel(int unsigned y, int unsigned x);
    road_res_t   res;
    int unsigned d0, d1, i0, i1, h0, h1, p0, p1, off;
    logic [1:0]  ctrl;
    bit          has_bg, use1;
    int unsigned bg;
    res = '0;
    if (y >= SCREEN_LINES || x >= LINE_LIMIT) return res;
    d0 = shown_word(y);
    d1 = shown_word('h100 + y);
    ctrl = m_mode[1:0];
    has_bg = 0;
    bg = 0;
    if (ctrl == MODE_ROAD0_ONLY || ctrl == MODE_ROAD0_FIRST) begin
      if (d0[11]) begin has_bg = 1; bg = d0 & 'h7f; end
      else if (ctrl == MODE_ROAD0_FIRST && d1[11]) begin has_bg = 1; bg = d1 & 'h7f; end
    end else begin
      if (d1[11]) begin has_bg = 1; bg = d1 & 'h7f; end
      else if (ctrl == MODE_ROAD1_FIRST && d0[11]) begin has_bg = 1; bg = d0 & 'h7f; end
    end
    if (!(d0[11] && d1[11]) && !(ctrl == MODE_ROAD0_ONLY && d0[11]) &&
        !(ctrl == MODE_ROAD1_ONLY && d1[11])) begin
      i0 = m_mode[2] ? y : (d0 & 'h1ff);
      i1 = m_mode[2] ? ('h100 + y) : (d1 & 'h1ff);
      off = ((SCROLL_BASE + m_shift) & 'hffff) + m_adj;
      h0 = ((shown_word('h200 + i0) & 'hfff) - off + x) & 'hfff;
      h1 = ((shown_word('h400 + i1) & 'hfff) - off + x) & 'hfff;
      p0 = road_value(0, d0, h0);
      p1 = road_value(1, d1, h1);
      case (ctrl)
        MODE_ROAD0_ONLY:  use1 = 0;
        MODE_ROAD1_ONLY:  use1 = 1;
        MODE_ROAD0_FIRST: use1 = PRIO_ROAD0_FIRST[p0 & 7][p1 & 7];
        default:          use1 = PRIO_ROAD1_FIRST[p0 & 7][p1 & 7];
      endcase
      res.pixel_write = 1'b1;
      res.pixel_color = use1 ? road_shade(1, p1, d1, shown_word('h600 + i1))
                             : road_shade(0, p0, d0, shown_word('h600 + i0));
    end else if (has_bg) begin
      res.pixel_write = 1'b1;
      res.pixel_color = 11'(bg) | m_solid;
    end
    return res;
  endfunction

  function automatic road_res_t apply_request(road_req_t q);
    road_res_t res;
    res = '0;
    case (q.kind)
      REQ_RAM_WR: road_ram[(!shown_bank)*RAM_WORDS + q.addr[10:0]] = q.wval;
      REQ_SWAP: begin
        shown_bank = !shown_bank;
        res.read_value = SWAP_RESULT;
      end
      REQ_ROM_LD: road_rom[q.addr] = q.wval[7:0];
      default: res = road_pixel(q.line, q.col);
    endcase
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_pixels.push_back(apply_request(held_req));
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && (calm() || $urandom_range(0, 99) >= 21)) begin
          held_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, held_req.col, held_req.line, held_req.wval, held_req.addr};
          in_tuser  <= held_req.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    road_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transfer %h", out_tdata);
          err_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_tdata[0] !== want.pixel_write) begin
            $error("pixel_write: expected %0d, got %0d", want.pixel_write, out_tdata[0]);
            err_count++;
          end
          if (out_tdata[11:1] !== want.pixel_color) begin
            $error("pixel_color: expected %0d, got %0d", want.pixel_color, out_tdata[11:1]);
            err_count++;
          end
          if (out_tdata[27:12] !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, out_tdata[27:12]);
            err_count++;
          end
        end
      end
      out_tready <= calm() || $urandom_range(0, 99) >= 21;
    end
  end

  task automatic add_req(logic [1:0] k, logic [15:0] a, logic [15:0] w,
                         logic [7:0] y, logic [8:0] x);
    road_req_t q;
    q.kind = k; q.addr = a; q.wval = w; q.line = y; q.col = x;
    pending_reqs.push_back(q);
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() > 0 || in_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [11:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_ROAD_MODE:   m_mode   = v[2:0];
      CFG_STRIPE_BASE: m_stripe = v[10:0];
      CFG_GROUND_BASE: m_ground = v[10:0];
      CFG_SOLID_BASE:  m_solid  = v[10:0];
      CFG_SCROLL_ADJ:  m_adj    = v;
      default:         m_shift  = v;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_reqs(int n);
    int unsigned pick;
    logic [15:0] a;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        add_req(REQ_RENDER, 16'($urandom), 16'($urandom),
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(224, 255))
                                            : 8'(lines_used[$urandom_range(0, 3)]),
                ($urandom_range(0, 9) == 0) ? 9'($urandom_range(320, 511))
                                            : 9'($urandom_range(0, 319)));
      else if (pick < 80) begin
        a = {5'($urandom), ram_keys[$urandom_range(0, ram_keys.size() - 1)][10:0]};
        add_req(REQ_RAM_WR, a, key_value(a), 8'($urandom), 9'($urandom));
      end else if (pick < 90)
        add_req(REQ_ROM_LD, rom_key(), 16'($urandom), 8'($urandom), 9'($urandom));
      else
        add_req(REQ_SWAP, 16'($urandom), 16'($urandom), 8'($urandom), 9'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    out_tready = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    shown_bank = 1'b0; m_mode = '0; m_stripe = 11'd1024; m_ground = 11'd1056;
    m_solid = 11'd1920; m_adj = '0; m_shift = '0;
    foreach (lines_used[j]) begin
      ram_keys.push_back(16'(lines_used[j]));
      ram_keys.push_back(16'('h100 + lines_used[j]));
      ram_keys.push_back(16'('h200 + lines_used[j]));
      ram_keys.push_back(16'('h500 + lines_used[j]));
      ram_keys.push_back(16'('h600 + lines_used[j]));
      ram_keys.push_back(16'('h700 + lines_used[j]));
    end
    for (int j = 0; j < 2; j++) begin
      ram_keys.push_back(16'('h200 + j));
      ram_keys.push_back(16'('h400 + j));
      ram_keys.push_back(16'('h600 + j));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // fill every ROM byte and RAM word in both banks that a render can reach
    for (int p = 0; p < 4; p++)
      for (int a = 0; a < 64; a++)
        add_req(REQ_ROM_LD, 16'(p * 'h4000 + a), 16'($urandom), 8'($urandom),
                9'($urandom));
    for (int b = 0; b < 2; b++) begin
      foreach (ram_keys[k])
        add_req(REQ_RAM_WR, ram_keys[k], key_value(ram_keys[k]), 8'($urandom),
                9'($urandom));
      add_req(REQ_SWAP, 16'hffff, 16'hffff, 8'hff, 9'h1ff);
    end

    // field extremes and off-screen edges
    add_req(REQ_RAM_WR, 16'hffff, 16'hffff, 8'hff, 9'h1ff);
    add_req(REQ_RAM_WR, 16'h0000, 16'h0000, 8'h00, 9'h000);
    add_req(REQ_ROM_LD, 16'hffff, 16'hffff, 8'h00, 9'h000);
    add_req(REQ_ROM_LD, 16'h0000, 16'h0000, 8'hff, 9'h1ff);
    add_req(REQ_RENDER, 16'hffff, 16'hffff, 8'd0, 9'd0);
    add_req(REQ_RENDER, 16'h0000, 16'h0000, 8'd223, 9'd319);
    add_req(REQ_RENDER, 16'h0000, 16'h0000, 8'd224, 9'd0);
    add_req(REQ_RENDER, 16'h0000, 16'h0000, 8'd0, 9'd320);
    add_req(REQ_RENDER, 16'hffff, 16'hffff, 8'd255, 9'd511);
    add_req(REQ_SWAP, 16'h0000, 16'h0000, 8'd0, 9'd0);
    add_req(REQ_RENDER, 16'h0000, 16'h0000, 8'd100, 9'd200);
    add_req(REQ_SWAP, 16'h0000, 16'h0000, 8'd0, 9'd0);
    random_reqs(90);
    wait_quiet();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ROAD_MODE, 12'(ph));
      write_reg(CFG_STRIPE_BASE, (ph == 1) ? 12'd0 : (ph == 2) ? 12'd2047 : 12'($urandom));
      write_reg(CFG_GROUND_BASE, (ph == 1) ? 12'd0 : (ph == 2) ? 12'd2047 : 12'($urandom));
      write_reg(CFG_SOLID_BASE, (ph == 1) ? 12'd0 : (ph == 2) ? 12'd2047 : 12'($urandom));
      write_reg(CFG_SCROLL_ADJ, (ph == 3) ? 12'd0 : (ph == 4) ? 12'hfff : 12'($urandom));
      write_reg(CFG_SCREEN_SHIFT, (ph == 3) ? 12'hfff : (ph == 4) ? 12'd0 : 12'($urandom));
      random_reqs(55);
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("tb_road_layer_pixel_generator_core: clean");
    else
      $display("tb_road_layer_pixel_generator_core: errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_road_layer_pixel_generator_core: errors");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hdl/rlpg_pkg.sv
hdl/rlpg_mix.sv
hdl/road_layer_pixel_generator_core.sv
tb/tb_road_layer_pixel_generator_core.sv
